// ----- hw/rtl/ssub_pkg.sv -----
// Shared types, constants and helper functions for the SPI-to-UART bridge.
package ssub_pkg;

    // Ring geometry; the index width follows from the depth.
    localparam int RING_DEPTH = 256;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int BYTE_W     = 8;

    // Exit string matcher.
    localparam int EXIT_LEN = 12;
    localparam int MATCH_W  = 4;

    // Depths of the command queue and the result queue, with their pointer and count widths.
    localparam int CMD_Q_DEPTH = 2;
    localparam int CMD_PTR_W   = $clog2(CMD_Q_DEPTH);
    localparam int CMD_CNT_W   = $clog2(CMD_Q_DEPTH + 1);
    localparam int RES_Q_DEPTH = 4;
    localparam int RES_PTR_W   = $clog2(RES_Q_DEPTH);
    localparam int RES_CNT_W   = $clog2(RES_Q_DEPTH + 1);

    // Protocol phase bits.
    localparam logic [BYTE_W-1:0] PHASE_CMD_MASK = 8'hC0;
    localparam logic [BYTE_W-1:0] PHASE_LEN_MASK = 8'h30;
    localparam logic [BYTE_W-1:0] PHASE_READ     = 8'h02;
    localparam logic [BYTE_W-1:0] PHASE_WRITE    = 8'h01;

    // Event kinds of an input word.
    typedef enum logic [1:0] {
        KIND_SPI     = 2'd0,
        KIND_UART_RX = 2'd1,
        KIND_TX_SLOT = 2'd2,
        KIND_START   = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [BYTE_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_reply;
        logic              reply_loaded;
        logic              rx_accepted;
        logic              tx_valid;
        logic [BYTE_W-1:0] tx_byte;
        logic              exit_matched;
    } result_t;

    // Characters of the exit string, in order.
    function automatic logic [BYTE_W-1:0] exit_char(input logic [MATCH_W-1:0] pos);
        logic [BYTE_W-1:0] c;
        begin
            case (pos)
                4'd0:    c = 8'h4A;
                4'd1:    c = 8'h4D;
                4'd2:    c = 8'h54;
                4'd3:    c = 8'h2B;
                4'd4:    c = 8'h45;
                4'd5:    c = 8'h43;
                4'd6:    c = 8'h48;
                4'd7:    c = 8'h4F;
                4'd8:    c = 8'h3D;
                4'd9:    c = 8'h30;
                4'd10:   c = 8'h0D;
                4'd11:   c = 8'h0A;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

    // Next ring index with wrap at the ring depth.
    function automatic logic [IDX_W-1:0] ring_inc(input logic [IDX_W-1:0] idx);
        begin
            return (idx == IDX_W'(RING_DEPTH - 1)) ? '0 : idx + 1'b1;
        end
    endfunction

    // Number of bytes held in a ring, as a byte.
    function automatic logic [BYTE_W-1:0] ring_count(input logic [IDX_W-1:0] fill,
                                                     input logic [IDX_W-1:0] drain);
        logic [IDX_W:0] t;
        begin
            if (fill >= drain)
                t = {1'b0, fill} - {1'b0, drain};
            else
                t = {1'b0, fill} + (IDX_W+1)'(RING_DEPTH) - {1'b0, drain};
            return BYTE_W'(t);
        end
    endfunction

endpackage

// ----- hw/rtl/ssub_front.sv -----
// Front end: accepts input words, decodes their kind and queues them for the back end.
module ssub_front
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    output logic                   full,
    input  logic [1:0]             kind,
    input  logic [7:0]             data_byte,
    output logic                   cmd_valid,
    output ssub_pkg::cmd_t         cmd,
    input  logic                   cmd_take
);

    ssub_pkg::cmd_t slot_reg [ssub_pkg::CMD_Q_DEPTH];
    logic [ssub_pkg::CMD_PTR_W-1:0] wr_ptr_reg;
    logic [ssub_pkg::CMD_PTR_W-1:0] wr_ptr_next;
    logic [ssub_pkg::CMD_PTR_W-1:0] rd_ptr_reg;
    logic [ssub_pkg::CMD_PTR_W-1:0] rd_ptr_next;
    logic [ssub_pkg::CMD_CNT_W-1:0] count_reg;
    logic [ssub_pkg::CMD_CNT_W-1:0] count_next;
    logic       do_push;
    logic       do_pop;
    ssub_pkg::cmd_t in_cmd;

    // Decode the incoming word.
    always_comb
    begin
        in_cmd.kind = ssub_pkg::kind_t'(kind);
        in_cmd.data = data_byte;
    end

    assign full      = (count_reg == ssub_pkg::CMD_CNT_W'(ssub_pkg::CMD_Q_DEPTH));
    assign cmd_valid = (count_reg != '0);
    assign cmd       = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = cmd_take && cmd_valid;

    // Pointer and fill count update; pointers wrap at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == ssub_pkg::CMD_PTR_W'(ssub_pkg::CMD_Q_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == ssub_pkg::CMD_PTR_W'(ssub_pkg::CMD_Q_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        count_next  = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!do_push && do_pop)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage holds payload only.
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= in_cmd;
    end

endmodule

// ----- hw/rtl/ssub_back.sv -----
// Back end: SPI protocol, UART rings, exit matcher; one word per cycle unless stalled.
module ssub_back
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cmd_valid,
    input  ssub_pkg::cmd_t                    cmd,
    output logic                              cmd_take,
    input  logic [ssub_pkg::RES_CNT_W-1:0]    res_count,
    output logic                              res_push,
    output ssub_pkg::result_t                 res
);

    typedef struct packed {
        logic [ssub_pkg::BYTE_W-1:0] reply_cnt;
        logic                        reply_from_ring;
        logic                        loaded;
        logic                        acc;
        logic                        txv;
        logic                        ex;
    } stage_t;

    // Ring memories; their contents are undefined until written.
    logic [ssub_pkg::BYTE_W-1:0] read_ring  [ssub_pkg::RING_DEPTH];
    logic [ssub_pkg::BYTE_W-1:0] write_ring [ssub_pkg::RING_DEPTH];
    logic [ssub_pkg::BYTE_W-1:0] read_data_reg;
    logic [ssub_pkg::BYTE_W-1:0] tx_data_reg;

    logic [ssub_pkg::IDX_W-1:0]   rf_reg, rf_next, rd_reg, rd_next;
    logic [ssub_pkg::IDX_W-1:0]   wf_reg, wf_next, wd_reg, wd_next;
    logic [ssub_pkg::BYTE_W-1:0]  phase_reg, phase_next;
    logic [ssub_pkg::BYTE_W-1:0]  pwc_reg, pwc_next, prc_reg, prc_next;
    logic [ssub_pkg::MATCH_W-1:0] match_reg, match_next;
    logic                         active_reg, active_next;
    logic                         s2_valid_reg;
    stage_t                       s2_reg;
    stage_t                       s1;
    logic                         rr_we;
    logic                         wr_we;
    logic                         exec;
    logic [ssub_pkg::RES_CNT_W:0] used;

    // Issue only when the result queue has room for this word and the one in flight.
    assign used     = {1'b0, res_count} + (ssub_pkg::RES_CNT_W+1)'(s2_valid_reg);
    assign exec     = cmd_valid && (used < (ssub_pkg::RES_CNT_W+1)'(ssub_pkg::RES_Q_DEPTH));
    assign cmd_take = exec;

    // Protocol and ring control for one word.
    always_comb
    begin
        logic [ssub_pkg::BYTE_W-1:0] ph;
        logic [ssub_pkg::BYTE_W-1:0] avail;
        logic [ssub_pkg::BYTE_W-1:0] prc_base;
        logic [ssub_pkg::BYTE_W-1:0] prc_v;
        logic [ssub_pkg::BYTE_W-1:0] pwc_v;
        logic                        do_read;

        rf_next     = rf_reg;
        rd_next     = rd_reg;
        wf_next     = wf_reg;
        wd_next     = wd_reg;
        phase_next  = phase_reg;
        pwc_next    = pwc_reg;
        prc_next    = prc_reg;
        match_next  = match_reg;
        active_next = active_reg;
        s1          = '0;
        rr_we       = 1'b0;
        wr_we       = 1'b0;
        ph          = phase_reg;
        avail       = ssub_pkg::ring_count(rf_reg, rd_reg);
        prc_base    = prc_reg;
        prc_v       = prc_reg;
        pwc_v       = pwc_reg;
        do_read     = 1'b0;

        if (exec)
        begin
            if (cmd.kind == ssub_pkg::KIND_START)
            begin
                rf_next     = '0;
                rd_next     = '0;
                wf_next     = '0;
                wd_next     = '0;
                phase_next  = '0;
                pwc_next    = '0;
                prc_next    = '0;
                match_next  = '0;
                active_next = 1'b1;
            end
            else if (active_reg)
            begin
                case (cmd.kind)
                    ssub_pkg::KIND_SPI:
                    begin
                        if (phase_reg == '0)
                        begin
                            // Command byte: reply with the read count.
                            ph           = cmd.data & ssub_pkg::PHASE_CMD_MASK;
                            s1.reply_cnt = avail;
                            s1.loaded    = 1'b1;
                        end
                        else if ((phase_reg & ssub_pkg::PHASE_CMD_MASK) != '0)
                        begin
                            // Write-length byte: reply with the write count.
                            ph           = phase_reg >> 2;
                            pwc_next     = cmd.data;
                            s1.reply_cnt = ssub_pkg::ring_count(wf_reg, wd_reg);
                            s1.loaded    = 1'b1;
                        end
                        else if ((phase_reg & ssub_pkg::PHASE_LEN_MASK) != '0)
                        begin
                            // Read-length byte, clamped to what the ring holds.
                            ph       = phase_reg >> 4;
                            prc_base = (cmd.data > avail) ? avail : cmd.data;
                            prc_next = prc_base;
                            if (pwc_reg == '0)
                                ph = ph & ~ssub_pkg::PHASE_WRITE;
                            if (prc_base == '0)
                                ph = ph & ~ssub_pkg::PHASE_READ;
                            else
                                do_read = 1'b1;
                        end
                        else
                        begin
                            // Data byte in both directions.
                            s1.loaded = 1'b1;
                            if ((phase_reg & ssub_pkg::PHASE_READ) != '0)
                                do_read = 1'b1;
                            if ((phase_reg & ssub_pkg::PHASE_WRITE) != '0)
                            begin
                                wr_we = 1'b1;
                                if (ssub_pkg::ring_inc(wf_reg) != wd_reg)
                                    wf_next = ssub_pkg::ring_inc(wf_reg);
                                if (pwc_reg != '0)
                                    pwc_v = pwc_reg - 1'b1;
                                pwc_next = pwc_v;
                                if (pwc_v == '0)
                                    ph = ph & ~ssub_pkg::PHASE_WRITE;
                            end
                        end

                        // Reply from the read ring and count the read down.
                        if (do_read)
                        begin
                            s1.reply_from_ring = 1'b1;
                            s1.loaded          = 1'b1;
                            if (rd_reg != rf_reg)
                                rd_next = ssub_pkg::ring_inc(rd_reg);
                            if (prc_base != '0)
                                prc_v = prc_base - 1'b1;
                            else
                                prc_v = prc_base;
                            prc_next = prc_v;
                            if (prc_v == '0)
                                ph = ph & ~ssub_pkg::PHASE_READ;
                        end
                        phase_next = ph;
                    end

                    ssub_pkg::KIND_UART_RX:
                    begin
                        if (ssub_pkg::ring_inc(rf_reg) != rd_reg)
                        begin
                            s1.acc  = 1'b1;
                            rr_we   = 1'b1;
                            rf_next = ssub_pkg::ring_inc(rf_reg);
                            if (cmd.data == ssub_pkg::exit_char(match_reg))
                            begin
                                if (match_reg == ssub_pkg::MATCH_W'(ssub_pkg::EXIT_LEN - 1))
                                begin
                                    s1.ex       = 1'b1;
                                    match_next  = '0;
                                    active_next = 1'b0;
                                end
                                else
                                begin
                                    match_next = match_reg + 1'b1;
                                end
                            end
                            else
                            begin
                                match_next = '0;
                            end
                        end
                    end

                    ssub_pkg::KIND_TX_SLOT:
                    begin
                        if (wd_reg != wf_reg)
                        begin
                            s1.txv  = 1'b1;
                            wd_next = ssub_pkg::ring_inc(wd_reg);
                        end
                    end

                    default:
                    begin
                        s1 = '0;
                    end
                endcase
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rf_reg       <= '0;
            rd_reg       <= '0;
            wf_reg       <= '0;
            wd_reg       <= '0;
            phase_reg    <= '0;
            pwc_reg      <= '0;
            prc_reg      <= '0;
            match_reg    <= '0;
            active_reg   <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            rf_reg       <= rf_next;
            rd_reg       <= rd_next;
            wf_reg       <= wf_next;
            wd_reg       <= wd_next;
            phase_reg    <= phase_next;
            pwc_reg      <= pwc_next;
            prc_reg      <= prc_next;
            match_reg    <= match_next;
            active_reg   <= active_next;
            s2_valid_reg <= exec;
        end
    end

    // Ring writes and registered reads at the drain indices.
    always_ff @(posedge clk)
    begin
        if (rr_we)
            read_ring[rf_reg] <= cmd.data;
        if (wr_we)
            write_ring[wf_reg] <= cmd.data;
        if (exec)
        begin
            read_data_reg <= read_ring[rd_reg];
            tx_data_reg   <= write_ring[wd_reg];
            s2_reg        <= s1;
        end
    end

    // Assemble the result word.
    always_comb
    begin
        res_push           = s2_valid_reg;
        res.spi_reply      = s2_reg.reply_from_ring ? read_data_reg : s2_reg.reply_cnt;
        res.reply_loaded   = s2_reg.loaded;
        res.rx_accepted    = s2_reg.acc;
        res.tx_valid       = s2_reg.txv;
        res.tx_byte        = s2_reg.txv ? tx_data_reg : '0;
        res.exit_matched   = s2_reg.ex;
    end

endmodule

// ----- hw/rtl/ssub_resq.sv -----
// Result queue: holds finished result words until they are popped.
module ssub_resq
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    input  ssub_pkg::result_t                 din,
    output logic [ssub_pkg::RES_CNT_W-1:0]    count,
    output logic                              empty,
    input  logic                              pop,
    output ssub_pkg::result_t                 dout
);

    ssub_pkg::result_t              slot_reg [ssub_pkg::RES_Q_DEPTH];
    logic [ssub_pkg::RES_PTR_W-1:0] wr_ptr_reg;
    logic [ssub_pkg::RES_PTR_W-1:0] rd_ptr_reg;
    logic [ssub_pkg::RES_CNT_W-1:0] count_reg;
    logic [ssub_pkg::RES_CNT_W-1:0] count_next;
    logic                           do_pop;

    assign empty  = (count_reg == '0);
    assign count  = count_reg;
    assign dout   = slot_reg[rd_ptr_reg];
    assign do_pop = pop && !empty;

    // Fill count; the back end never pushes into a full queue.
    always_comb
    begin
        count_next = count_reg;
        if (push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (!push && do_pop)
            count_next = count_reg - 1'b1;
    end

    // Pointers wrap at the queue depth.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == ssub_pkg::RES_PTR_W'(ssub_pkg::RES_Q_DEPTH - 1)) ?
                              '0 : wr_ptr_reg + 1'b1;
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == ssub_pkg::RES_PTR_W'(ssub_pkg::RES_Q_DEPTH - 1)) ?
                              '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= din;
    end

endmodule

// ----- hw/rtl/spi_slave_uart_bridge_fifo_top.sv -----
// Top level of the SPI-slave to UART bridge with read and write rings.
// A word's result is registered in the back end, then written into the result queue.
// Throughput: one word per cycle; the back end issues a word each cycle and reads the rings
// through registered ports, and stalls only when the result queue has no room.
// Reset: asynchronous, clears ring indices, protocol phase, counts, matcher and both queues.
// Ring contents are not cleared at reset and there is no clearing pass.
module spi_slave_uart_bridge_fifo_top
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       push,
    output logic       full,
    input  logic [1:0] kind,
    input  logic [7:0] data_byte,
    output logic       empty,
    input  logic       pop,
    output logic [7:0] spi_reply,
    output logic       reply_loaded,
    output logic       rx_accepted,
    output logic       tx_valid,
    output logic [7:0] tx_byte,
    output logic       exit_matched
);

    logic                           cmd_valid;
    logic                           cmd_take;
    ssub_pkg::cmd_t                 cmd;
    logic [ssub_pkg::RES_CNT_W-1:0] res_count;
    logic                           res_push;
    ssub_pkg::result_t              res;
    ssub_pkg::result_t              res_out;

    ssub_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .kind      (kind),
        .data_byte (data_byte),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    ssub_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take),
        .res_count (res_count),
        .res_push  (res_push),
        .res       (res)
    );

    ssub_resq u_resq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (res),
        .count (res_count),
        .empty (empty),
        .pop   (pop),
        .dout  (res_out)
    );

    // Result word onto the ports.
    assign spi_reply    = res_out.spi_reply;
    assign reply_loaded = res_out.reply_loaded;
    assign rx_accepted  = res_out.rx_accepted;
    assign tx_valid     = res_out.tx_valid;
    assign tx_byte      = res_out.tx_byte;
    assign exit_matched = res_out.exit_matched;

    // The result queue is never pushed while it is full.
    assert property (@(posedge clk) disable iff (!rst_n)
        res_push |-> (res_count < ssub_pkg::RES_CNT_W'(ssub_pkg::RES_Q_DEPTH)))
        else $error("result queue overflow");

    // An exit match only comes with a byte taken into the read ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && exit_matched) |-> rx_accepted)
        else $error("exit match without accepted byte");

    // A result word describes at most one kind of event.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ($countones({reply_loaded, rx_accepted, tx_valid}) <= 1))
        else $error("result word mixes events");

    // Unloaded replies and idle transmit slots carry zero bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> ((reply_loaded || spi_reply == 8'd0) && (tx_valid || tx_byte == 8'd0)))
        else $error("nonzero byte in unused field");

endmodule
